// ===== rtl/core/slm_pkg.sv =====
// Shared types, constants and the segment table of the sound level meter.
package slm_pkg;

   localparam int SAMPLE_W        = 10;
   localparam int MIN_W           = SAMPLE_W + 1;
   localparam int SUM_W           = 20;
   localparam int LEVEL_W         = 11;
   localparam int DIVIDEND_W      = 24;
   localparam int RANGE_W         = 9;
   localparam int MAX_WINDOWS_DEF = 1024;

   localparam logic [SUM_W-1:0]    SUM_LIMIT  = '1;
   localparam logic [MIN_W-1:0]    MIN_RESET  = 11'd1024;
   localparam logic [SUM_W-1:0]    LOW_SEG_END = 20'd410;
   localparam logic [LEVEL_W-1:0]  LOW_OFFSET  = 11'd778;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_WINDOW = 2'd1,
      CMD_PERIOD = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_AVG,
      ST_MAP,
      ST_DIV_LEVEL,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                sample;
      logic                close;
      logic                clear;
      logic [SAMPLE_W-1:0] value;
   } trk_ctrl_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] in_lo;
      logic [3:0]          span;
      logic [RANGE_W-1:0]  in_range;
      logic [6:0]          out_lo;
   } seg_type;

   // Segments above the lowest one; the lowest maps exactly to 2*avg - 778.
   function automatic seg_type seg_of(input logic [SUM_W-1:0] avg);
      seg_type s;
      if (avg < 20'd422) begin
         s = '{in_lo: 10'd410, span: 4'd8, in_range: 9'd12, out_lo: 7'd42};
      end else if (avg < 20'd537) begin
         s = '{in_lo: 10'd422, span: 4'd10, in_range: 9'd115, out_lo: 7'd50};
      end else if (avg < 20'd790) begin
         s = '{in_lo: 10'd537, span: 4'd10, in_range: 9'd253, out_lo: 7'd60};
      end else begin
         s = '{in_lo: 10'd790, span: 4'd9, in_range: 9'd310, out_lo: 7'd70};
      end
      return s;
   endfunction

endpackage

// ===== rtl/core/slm_tracker.sv =====
// Window minimum and maximum tracker with the saturating peak sum and window count.
module slm_tracker
   import slm_pkg::*;
#(
   parameter int MAX_WINDOWS = MAX_WINDOWS_DEF,
   parameter int COUNT_W     = $clog2(MAX_WINDOWS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  trk_ctrl_type        ctrl,
   output logic [SAMPLE_W-1:0] peak,
   output logic [SUM_W-1:0]    peak_sum,
   output logic [COUNT_W-1:0]  window_count
);

   logic [SAMPLE_W-1:0] window_max_ff, window_max_in;
   logic [MIN_W-1:0]    window_min_ff, window_min_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [SUM_W:0]      sum_add;

   always_comb begin
      peak = '0;
      if (window_min_ff <= {1'b0, window_max_ff}) begin
         peak = window_max_ff - window_min_ff[SAMPLE_W-1:0];
      end
      sum_add       = {1'b0, sum_ff} + {{(SUM_W + 1 - SAMPLE_W){1'b0}}, peak};
      window_max_in = window_max_ff;
      window_min_in = window_min_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      if (ctrl.sample) begin
         if (ctrl.value > window_max_ff) begin
            window_max_in = ctrl.value;
         end
         if ({1'b0, ctrl.value} < window_min_ff) begin
            window_min_in = {1'b0, ctrl.value};
         end
      end
      if (ctrl.close) begin
         window_max_in = '0;
         window_min_in = MIN_RESET;
         if (count_ff < COUNT_W'(MAX_WINDOWS)) begin
            sum_in   = sum_add[SUM_W] ? SUM_LIMIT : sum_add[SUM_W-1:0];
            count_in = count_ff + COUNT_W'(1);
         end
      end
      if (ctrl.clear) begin
         sum_in   = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_max_ff <= '0;
         window_min_ff <= MIN_RESET;
         sum_ff        <= '0;
         count_ff      <= '0;
      end else begin
         window_max_ff <= window_max_in;
         window_min_ff <= window_min_in;
         sum_ff        <= sum_in;
         count_ff      <= count_in;
      end
   end

   assign peak_sum     = sum_ff;
   assign window_count = count_ff;

endmodule

// ===== rtl/core/slm_divider.sv =====
// Bit-serial restoring divider that produces one quotient bit per cycle.
module slm_divider
   import slm_pkg::*;
#(
   parameter int DIVISOR_W = RANGE_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff    = trial - {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DIVIDEND_W);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/sound_level_meter.sv =====
// Top level of the sound level meter: command sequencer, level mapping and result register.
// A sample, window-close or unused command passes through the emit state to the output
// register, and the next transfer is taken once the result has been registered there.
// A period end runs a 24-step divider pass for the average, then the mapping state and,
// outside the lowest segment, a second pass; with no windows it goes straight to emit.
// Synchronous reset clears the sequencer, the output valid flag and the window tracker.
module sound_level_meter
   import slm_pkg::*;
#(
   parameter int MAX_WINDOWS = MAX_WINDOWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [9:0] sample_value
   input  logic [1:0]  req_tuser,  // [1:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // [10:0] level_db, [20:11] window_peak
   output logic [0:0]  rsp_tuser   // [0] level_valid
);

   localparam int COUNT_W   = $clog2(MAX_WINDOWS + 1);
   localparam int DIVISOR_W = (COUNT_W > RANGE_W) ? COUNT_W : RANGE_W;

   state_type state_ff, state_in;

   trk_ctrl_type          trk_ctrl;
   logic [SAMPLE_W-1:0]   trk_peak;
   logic [SUM_W-1:0]      trk_sum;
   logic [COUNT_W-1:0]    trk_count;

   logic                  div_start;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] div_quotient;

   logic [SUM_W-1:0]      avg_ff, avg_in;
   logic                  res_valid_ff, res_valid_in;
   logic [LEVEL_W-1:0]    res_level_ff, res_level_in;
   logic [SAMPLE_W-1:0]   res_peak_ff, res_peak_in;

   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic                  rsp_level_valid_ff, rsp_level_valid_in;
   logic [LEVEL_W-1:0]    rsp_level_ff, rsp_level_in;
   logic [SAMPLE_W-1:0]   rsp_peak_ff, rsp_peak_in;

   logic                  req_take;
   cmd_type               req_cmd;
   seg_type               seg;
   logic [SUM_W-1:0]      seg_diff;
   logic [DIVIDEND_W-1:0] seg_num;

   slm_tracker #(
      .MAX_WINDOWS(MAX_WINDOWS),
      .COUNT_W    (COUNT_W)
   ) u_tracker (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (trk_ctrl),
      .peak        (trk_peak),
      .peak_sum    (trk_sum),
      .window_count(trk_count)
   );

   slm_divider #(
      .DIVISOR_W(DIVISOR_W)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .done    (div_done),
      .quotient(div_quotient)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign req_cmd    = cmd_type'(req_tuser);

   always_comb begin
      seg      = seg_of(avg_ff);
      seg_diff = avg_ff - {{(SUM_W - SAMPLE_W){1'b0}}, seg.in_lo};
      seg_num  = {{(DIVIDEND_W - SUM_W){1'b0}}, seg_diff} * {{(DIVIDEND_W - 4){1'b0}}, seg.span};
   end

   always_comb begin
      state_in           = state_ff;
      trk_ctrl           = '{sample: 1'b0, close: 1'b0, clear: 1'b0,
                             value: req_tdata[SAMPLE_W-1:0]};
      div_start          = 1'b0;
      div_dividend       = {{(DIVIDEND_W - SUM_W){1'b0}}, trk_sum};
      div_divisor        = DIVISOR_W'(trk_count);
      avg_in             = avg_ff;
      res_valid_in       = res_valid_ff;
      res_level_in       = res_level_ff;
      res_peak_in        = res_peak_ff;
      rsp_tvalid_in      = rsp_tvalid_ff;
      rsp_level_valid_in = rsp_level_valid_ff;
      rsp_level_in       = rsp_level_ff;
      rsp_peak_in        = rsp_peak_ff;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               res_valid_in = 1'b0;
               res_level_in = '0;
               res_peak_in  = '0;
               state_in     = ST_EMIT;
               case (req_cmd)
                  CMD_SAMPLE: begin
                     trk_ctrl.sample = 1'b1;
                  end
                  CMD_WINDOW: begin
                     trk_ctrl.close = 1'b1;
                     res_peak_in    = trk_peak;
                  end
                  CMD_PERIOD: begin
                     trk_ctrl.clear = 1'b1;
                     res_valid_in   = 1'b1;
                     if (trk_count == '0) begin
                        res_level_in = '0 - LOW_OFFSET;
                     end else begin
                        div_start = 1'b1;
                        state_in  = ST_DIV_AVG;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV_AVG: begin
            if (div_done) begin
               avg_in   = div_quotient[SUM_W-1:0];
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            if (avg_ff < LOW_SEG_END) begin
               res_level_in = {avg_ff[LEVEL_W-2:0], 1'b0} - LOW_OFFSET;
               state_in     = ST_EMIT;
            end else begin
               div_start    = 1'b1;
               div_dividend = seg_num;
               div_divisor  = DIVISOR_W'(seg.in_range);
               state_in     = ST_DIV_LEVEL;
            end
         end
         ST_DIV_LEVEL: begin
            if (div_done) begin
               res_level_in = div_quotient[LEVEL_W-1:0]
                            + {{(LEVEL_W - 7){1'b0}}, seg.out_lo};
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in      = 1'b1;
               rsp_level_valid_in = res_valid_ff;
               rsp_level_in       = res_level_ff;
               rsp_peak_in        = res_peak_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      avg_ff             <= avg_in;
      res_valid_ff       <= res_valid_in;
      res_level_ff       <= res_level_in;
      res_peak_ff        <= res_peak_in;
      rsp_level_valid_ff <= rsp_level_valid_in;
      rsp_level_ff       <= rsp_level_in;
      rsp_peak_ff        <= rsp_peak_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {3'b000, rsp_peak_ff, rsp_level_ff};
   assign rsp_tuser  = rsp_level_valid_ff;

`ifndef SYNTHESIS
   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && rsp_tvalid_ff && !rsp_tready |=> (state_ff == ST_EMIT))
      else $error("pending result left the sequencer while the output was stalled");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> ((state_ff == ST_DIV_AVG) || (state_ff == ST_DIV_LEVEL)))
      else $error("divider finished outside a divide state");

   a_level_no_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && rsp_level_valid_ff |-> (rsp_peak_ff == '0))
      else $error("level result carries a window peak");

   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != ST_IDLE))
      else $error("transfer accepted without starting work");
`endif

endmodule

// ===== sim/sound_level_meter_tb.sv =====
// Self-checking testbench of the sound level meter: directed table, random periods and random single commands.
module sound_level_meter_tb;
   import slm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          MAX_WINDOWS  = MAX_WINDOWS_DEF;
   localparam logic [1:0]  CMD_UNUSED   = 2'd3;
   localparam logic [10:0] NO_WINDOW_DB = -11'sd778;
   localparam int          RANDOM_ITEMS = 700;
   localparam int          STALL_LIMIT  = 4000;
   localparam int          DRAIN_CYCLES = 120;
   localparam int          NORMAL_IDLE  = 28;

   typedef struct packed {
      logic        valid;
      logic [10:0] level;
      logic [9:0]  peak;
   } meter_rsp_type;

   typedef struct {
      logic [1:0]    cmd;
      logic [9:0]    value;
      bit            typed;
      meter_rsp_type rsp;
   } stim_row_type;

   localparam meter_rsp_type NO_REPORT = '0;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   meter_rsp_type pending_reports[$];
   int            error_count  = 0;
   int            stall_cycles = 0;
   int unsigned   idle_pct     = NORMAL_IDLE;
   int            sent_count   = 0;

   logic [9:0]  trk_max   = '0;
   logic [10:0] trk_min   = MIN_RESET;
   logic [19:0] acc_sum   = '0;
   logic [10:0] win_count = '0;

   stim_row_type directed_rows [24];

   sound_level_meter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic note_error(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic int db_of_average(input int avg);
      if (avg < 410) return (avg - 405) * 10 / 5 + 32;
      if (avg < 422) return (avg - 410) * 8 / 12 + 42;
      if (avg < 537) return (avg - 422) * 10 / 115 + 50;
      if (avg < 790) return (avg - 537) * 10 / 253 + 60;
      return (avg - 790) * 9 / 310 + 70;
   endfunction

   task automatic meter_step(input logic [1:0] cmd, input logic [9:0] value,
                             output meter_rsp_type rsp);
      int unsigned total;
      int unsigned avg;
      int          db;
      rsp = NO_REPORT;
      case (cmd)
         CMD_SAMPLE: begin
            if (value > trk_max) trk_max = value;
            if ({1'b0, value} < trk_min) trk_min = {1'b0, value};
         end
         CMD_WINDOW: begin
            if (trk_min <= {1'b0, trk_max}) rsp.peak = trk_max - trk_min[9:0];
            if (win_count < MAX_WINDOWS) begin
               total = acc_sum + rsp.peak;
               acc_sum = (total > SUM_LIMIT) ? SUM_LIMIT : total[19:0];
               win_count++;
            end
            trk_max = '0;
            trk_min = MIN_RESET;
         end
         CMD_PERIOD: begin
            avg = (win_count == 0) ? 0 : acc_sum / win_count;
            db = db_of_average(avg);
            rsp.valid = 1'b1;
            rsp.level = db[10:0];
            acc_sum = '0;
            win_count = '0;
         end
         default: ;
      endcase
   endtask

   task automatic send_item(input logic [1:0] cmd, input logic [9:0] value,
                            input bit typed = 1'b0, input meter_rsp_type typed_rsp = '0);
      meter_rsp_type predicted;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {6'd0, value};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      meter_step(cmd, value, predicted);
      pending_reports.push_back(typed ? typed_rsp : predicted);
      if (cmd != CMD_UNUSED) sent_count++;
   endtask

   task automatic wait_drained;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_reports.size() != 0);
   endtask

   task automatic send_window(input int peak);
      int lo;
      int extras;
      bit hi_first;
      lo = $urandom_range(0, 1023 - peak);
      hi_first = $urandom_range(0, 1);
      extras = $urandom_range(0, 2);
      repeat (extras) send_item(CMD_SAMPLE, 10'($urandom_range(lo, lo + peak)));
      send_item(CMD_SAMPLE, 10'(hi_first ? lo + peak : lo));
      extras = $urandom_range(0, 2);
      repeat (extras) send_item(CMD_SAMPLE, 10'($urandom_range(lo, lo + peak)));
      send_item(CMD_SAMPLE, 10'(hi_first ? lo : lo + peak));
      if ($urandom_range(0, 19) == 0) send_item(CMD_UNUSED, 10'($urandom_range(0, 1023)));
      send_item(CMD_WINDOW, 10'($urandom_range(0, 1023)));
   endtask

   task automatic send_period;
      int edges [6];
      int target;
      int n_windows;
      int peak;
      edges = '{0, 405, 410, 422, 537, 790};
      if ($urandom_range(0, 1) == 0) begin
         target = edges[$urandom_range(0, 5)] + $urandom_range(0, 6) - 3;
         if (target < 0) target = 0;
      end else begin
         target = $urandom_range(0, 1023);
      end
      n_windows = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      for (int w = 0; w < n_windows; w++) begin
         peak = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : target;
         if ($urandom_range(0, 14) == 0)
            send_item(CMD_WINDOW, 10'($urandom_range(0, 1023)));
         else
            send_window(peak);
      end
      send_item(CMD_PERIOD, 10'($urandom_range(0, 1023)));
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= idle_pct);
   end

   always @(posedge clock) begin
      meter_rsp_type got;
      meter_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tuser[0], rsp_tdata[10:0], rsp_tdata[20:11]};
         if (pending_reports.size() == 0) begin
            note_error($sformatf("result with nothing expected: valid %0d level %0d peak %0d",
                                 got.valid, $signed(got.level), got.peak));
         end else begin
            want = pending_reports.pop_front();
            if (got.valid !== want.valid)
               note_error($sformatf("level_valid got %0d expected %0d", got.valid, want.valid));
            if (got.level !== want.level)
               note_error($sformatf("level_db got %0d expected %0d",
                                    $signed(got.level), $signed(want.level)));
            if (got.peak !== want.peak)
               note_error($sformatf("window_peak got %0d expected %0d", got.peak, want.peak));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int random_start;
      int next_pause;
      directed_rows = '{
         '{CMD_PERIOD, 10'd0,    1'b1, '{1'b1, NO_WINDOW_DB, 10'd0}},
         '{CMD_WINDOW, 10'd1023, 1'b1, NO_REPORT},
         '{CMD_PERIOD, 10'd1023, 1'b1, '{1'b1, NO_WINDOW_DB, 10'd0}},
         '{CMD_SAMPLE, 10'd1023, 1'b1, NO_REPORT},
         '{CMD_SAMPLE, 10'd0,    1'b1, NO_REPORT},
         '{CMD_WINDOW, 10'd0,    1'b1, '{1'b0, 11'd0, 10'd1023}},
         '{CMD_UNUSED, 10'd1023, 1'b1, NO_REPORT},
         '{CMD_SAMPLE, 10'd512,  1'b1, NO_REPORT},
         '{CMD_WINDOW, 10'd512,  1'b1, NO_REPORT},
         '{CMD_PERIOD, 10'd0,    1'b0, NO_REPORT},
         '{CMD_SAMPLE, 10'd700,  1'b1, NO_REPORT},
         '{CMD_SAMPLE, 10'd300,  1'b1, NO_REPORT},
         '{CMD_SAMPLE, 10'd500,  1'b1, NO_REPORT},
         '{CMD_WINDOW, 10'd0,    1'b1, '{1'b0, 11'd0, 10'd400}},
         '{CMD_PERIOD, 10'd0,    1'b0, NO_REPORT},
         '{CMD_SAMPLE, 10'd100,  1'b1, NO_REPORT},
         '{CMD_SAMPLE, 10'd890,  1'b1, NO_REPORT},
         '{CMD_WINDOW, 10'd0,    1'b1, '{1'b0, 11'd0, 10'd790}},
         '{CMD_PERIOD, 10'd0,    1'b0, NO_REPORT},
         '{CMD_SAMPLE, 10'd0,    1'b1, NO_REPORT},
         '{CMD_SAMPLE, 10'd1023, 1'b1, NO_REPORT},
         '{CMD_WINDOW, 10'd0,    1'b1, '{1'b0, 11'd0, 10'd1023}},
         '{CMD_PERIOD, 10'd0,    1'b0, NO_REPORT},
         '{CMD_UNUSED, 10'd0,    1'b1, NO_REPORT}
      };
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].cmd, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].rsp);
      wait_drained;

      random_start = sent_count;
      next_pause = random_start + 200;
      while (sent_count < random_start + RANDOM_ITEMS) begin
         idle_pct = (sent_count >= random_start + 250 && sent_count < random_start + 400)
                    ? 0 : NORMAL_IDLE;
         if (sent_count >= next_pause) begin
            wait_drained;
            next_pause = sent_count + 200;
         end
         if ($urandom_range(0, 4) != 0)
            send_period;
         else
            send_item(2'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)));
      end
      idle_pct = NORMAL_IDLE;
      wait_drained;
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_reports.size() != 0)
         note_error($sformatf("%0d expected results never arrived", pending_reports.size()));
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
